// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: sv/lsct_pkg.sv
// package: constants, types and helpers of the line sensor centroid tracker
`default_nettype none

package lsct_pkg;

   localparam int CHANNELS     = 8;
   localparam int MASK_W       = 8;
   localparam int SAMPLE_W     = 12;
   localparam int DSUM_W       = 15;
   localparam int WEIGHT_W     = 10;
   localparam int PROD_W       = SAMPLE_W + 1 + WEIGHT_W;
   localparam int WSUM_W       = PROD_W + 3;
   localparam int COUNT_W      = 4;
   localparam int POS_W        = 14;
   localparam int LIMIT_W      = 13;
   localparam int QUOT_W       = 13;
   localparam int NUM_W        = WSUM_W + 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 15;
   localparam int DIV_CNT_W    = 4;

   localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << CHANNELS) - 1);

   // largest possible quotient: outermost weight times sixteen
   localparam logic [QUOT_W-1:0] MAX_MAG = QUOT_W'(50 * (CHANNELS - 1) * 16);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DARKNESS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACQUIRE_FRAMES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOST_FRAMES    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_SIGN    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITION_LIMIT = 3'd5;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RST_LINE_THRESHOLD = 12'd2048;
   localparam logic [DSUM_W-1:0]   RST_MIN_DARKNESS   = 15'd205;
   localparam logic [1:0]          RST_ACQUIRE_FRAMES = 2'd2;
   localparam logic [1:0]          RST_LOST_FRAMES    = 2'd3;
   localparam logic [LIMIT_W-1:0]  RST_POSITION_LIMIT = 13'd6400;

   typedef struct packed {
      logic                       is_dark;
      logic [SAMPLE_W-1:0]        dark;
      logic signed [PROD_W-1:0]   prod;
   } lane_result_type;

   typedef struct packed {
      logic                       busy;
      logic [QUOT_W-1:0]          quotient;
   } div_status_type;

   // fixed channel position: 50*(2i-(CHANNELS-1))
   function automatic logic signed [WEIGHT_W-1:0] lane_weight(input int idx);
      lane_weight = WEIGHT_W'(50 * (2 * idx - (CHANNELS - 1)));
   endfunction

endpackage

`default_nettype wire

// File: sv/lsct_if.sv
// interfaces: request and response channels of the tracker
`default_nettype none

interface lsct_req_if import lsct_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                read_ok;
   logic [MASK_W-1:0]   usable_mask;
   logic [MASK_W-1:0]   white_mask;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic [SAMPLE_W-1:0] sample_3;
   logic [SAMPLE_W-1:0] sample_4;
   logic [SAMPLE_W-1:0] sample_5;
   logic [SAMPLE_W-1:0] sample_6;
   logic [SAMPLE_W-1:0] sample_7;

   modport source (
      output valid, read_ok, usable_mask, white_mask,
             sample_0, sample_1, sample_2, sample_3,
             sample_4, sample_5, sample_6, sample_7,
      input  ready
   );

   modport sink (
      input  valid, read_ok, usable_mask, white_mask,
             sample_0, sample_1, sample_2, sample_3,
             sample_4, sample_5, sample_6, sample_7,
      output ready
   );
endinterface

interface lsct_rsp_if import lsct_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] filtered_position;
   logic                    line_detected;
   logic [COUNT_W-1:0]      dark_channel_count;
   logic [MASK_W-1:0]       track_mask;
   logic                    sensor_online;

   modport source (
      output valid, filtered_position, line_detected, dark_channel_count,
             track_mask, sensor_online,
      input  ready
   );

   modport sink (
      input  valid, filtered_position, line_detected, dark_channel_count,
             track_mask, sensor_online,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/line_sensor_centroid_tracker_unit.sv
// top level: line sensor centroid tracker with lanes, merge, divider and tracking
// a request steps through the lane, merge, start, divide and update states in order;
//    divide runs the 13-step quotient loop of the shared divider, update waits while
//    a held response is not yet taken; requests are taken only in the idle state
// a new request is taken while the previous response still waits in its register
// reset: synchronous, active high; clears control, tracking state and config to defaults
`default_nettype none

module line_sensor_centroid_tracker_unit import lsct_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lsct_req_if.sink                    req_bus,
   lsct_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_LANE,
      S_MERGE,
      S_START,
      S_DIVIDE,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [SAMPLE_W-1:0] thr_ff;
   logic [DSUM_W-1:0]   min_dark_ff;
   logic [1:0]          acq_frames_ff;
   logic [1:0]          lost_frames_ff;
   logic                invert_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   // captured frame
   logic                frame_ok_ff;
   logic [MASK_W-1:0]   vmask_ff;
   logic [MASK_W-1:0]   wmask_ff;
   logic [SAMPLE_W-1:0] samp_ff [CHANNELS];
   logic [SAMPLE_W-1:0] samp_in [MASK_W];

   // tracking state
   logic signed [POS_W-1:0] filt_ff, filt_in;
   logic                    det_ff, det_in;
   logic [1:0]              acq_ff, acq_in;
   logic [1:0]              lost_ff, lost_in;
   logic [COUNT_W-1:0]      last_count_ff, last_count_in;
   logic [MASK_W-1:0]       last_mask_ff, last_mask_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] out_pos_ff;
   logic                    out_det_ff;
   logic [COUNT_W-1:0]      out_count_ff;
   logic [MASK_W-1:0]       out_mask_ff;
   logic                    out_online_ff;

   // datapath
   lane_result_type          lane_res [CHANNELS];
   logic [DSUM_W-1:0]        dark_sum;
   logic signed [WSUM_W-1:0] wsum;
   logic [COUNT_W-1:0]       dark_tally;
   logic [WSUM_W-1:0]        wsum_abs;
   logic [NUM_W-1:0]         numerator;
   div_status_type           div_stat;

   logic                    req_fire;
   logic                    update_fire;
   logic [MASK_W-1:0]       tmask;
   logic                    raw_neg;
   logic signed [POS_W-1:0] raw;
   logic                    pos_valid;
   logic                    good;
   logic [POS_W-1:0]        filt_abs;
   logic signed [POS_W:0]   diff;
   logic signed [POS_W:0]   filt_sum;
   logic [1:0]              acq_step;
   logic [1:0]              lost_step;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign update_fire   = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_bus.ready);

   assign samp_in[0] = req_bus.sample_0;
   assign samp_in[1] = req_bus.sample_1;
   assign samp_in[2] = req_bus.sample_2;
   assign samp_in[3] = req_bus.sample_3;
   assign samp_in[4] = req_bus.sample_4;
   assign samp_in[5] = req_bus.sample_5;
   assign samp_in[6] = req_bus.sample_6;
   assign samp_in[7] = req_bus.sample_7;

   // one lane per channel, each with its fixed position weight
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      lsct_lane u_lane (
         .clock      (clock),
         .load       (state_ff == S_LANE),
         .chan_valid (vmask_ff[g]),
         .sample     (samp_ff[g]),
         .threshold  (thr_ff),
         .weight     (lane_weight(g)),
         .result     (lane_res[g])
      );
   end

   lsct_merge u_merge (
      .clock      (clock),
      .load       (state_ff == S_MERGE),
      .lanes      (lane_res),
      .dark_sum   (dark_sum),
      .wdark_sum  (wsum),
      .dark_tally (dark_tally)
   );

   // magnitude times sixteen, sign handled after the divide
   assign wsum_abs  = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
   assign numerator = {wsum_abs, 4'b0000};

   lsct_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (state_ff == S_START),
      .numerator   (numerator),
      .denominator (dark_sum),
      .status      (div_stat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LANE;
            end
         end
         S_LANE:   state_in = S_MERGE;
         S_MERGE:  state_in = S_START;
         S_START:  state_in = S_DIVIDE;
         S_DIVIDE: begin
            if (!div_stat.busy) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (update_fire) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // frame evaluation and tracking update
   always_comb begin
      tmask     = (~wmask_ff) & vmask_ff & CH_MASK;
      raw_neg   = wsum[WSUM_W-1] ^ invert_ff;
      raw       = raw_neg ? -$signed({1'b0, div_stat.quotient})
                          :  $signed({1'b0, div_stat.quotient});
      pos_valid = (dark_sum != '0) && (dark_sum >= min_dark_ff)
                  && (div_stat.quotient <= limit_ff);
      good      = pos_valid && (tmask != '0);

      filt_abs  = filt_ff[POS_W-1] ? POS_W'(-filt_ff) : POS_W'(filt_ff);
      diff      = (POS_W+1)'(raw) - (POS_W+1)'(filt_ff);
      filt_sum  = (POS_W+1)'(filt_ff) + (diff >>> 1);

      acq_step  = (acq_ff < acq_frames_ff) ? acq_ff + 2'd1 : acq_ff;
      lost_step = (lost_ff < lost_frames_ff) ? lost_ff + 2'd1 : lost_ff;

      filt_in       = filt_ff;
      det_in        = det_ff;
      acq_in        = acq_ff;
      lost_in       = lost_ff;
      last_count_in = last_count_ff;
      last_mask_in  = last_mask_ff;

      if (!frame_ok_ff) begin
         // failed read drops detection, holds filter and last frame info
         det_in  = 1'b0;
         acq_in  = '0;
         lost_in = '0;
      end else begin
         last_count_in = dark_tally;
         last_mask_in  = tmask;
         if (good) begin
            lost_in = '0;
            // filter out of range: restart from the raw position
            if (filt_abs > POS_W'(limit_ff)) begin
               filt_in = raw;
            end else begin
               filt_in = POS_W'(filt_sum);
            end
            if (!det_ff) begin
               acq_in = acq_step;
               if (acq_step >= acq_frames_ff) begin
                  det_in = 1'b1;
               end
            end else begin
               acq_in = acq_frames_ff;
            end
         end else begin
            acq_in = '0;
            if (!det_ff) begin
               lost_in = '0;
            end else begin
               lost_in = lost_step;
               if (lost_step >= lost_frames_ff) begin
                  det_in = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (update_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         thr_ff         <= RST_LINE_THRESHOLD;
         min_dark_ff    <= RST_MIN_DARKNESS;
         acq_frames_ff  <= RST_ACQUIRE_FRAMES;
         lost_frames_ff <= RST_LOST_FRAMES;
         invert_ff      <= 1'b0;
         limit_ff       <= RST_POSITION_LIMIT;
         filt_ff        <= '0;
         det_ff         <= 1'b0;
         acq_ff         <= '0;
         lost_ff        <= '0;
         last_count_ff  <= '0;
         last_mask_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_LINE_THRESHOLD: thr_ff         <= csr_wdata[SAMPLE_W-1:0];
               REG_MIN_DARKNESS:   min_dark_ff    <= csr_wdata[DSUM_W-1:0];
               REG_ACQUIRE_FRAMES: acq_frames_ff  <= csr_wdata[1:0];
               REG_LOST_FRAMES:    lost_frames_ff <= csr_wdata[1:0];
               REG_INVERT_SIGN:    invert_ff      <= csr_wdata[0];
               REG_POSITION_LIMIT: limit_ff       <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (update_fire) begin
            filt_ff       <= filt_in;
            det_ff        <= det_in;
            acq_ff        <= acq_in;
            lost_ff       <= lost_in;
            last_count_ff <= last_count_in;
            last_mask_ff  <= last_mask_in;
         end
      end
      // payload, no reset needed
      if (req_fire) begin
         frame_ok_ff <= req_bus.read_ok;
         vmask_ff    <= req_bus.usable_mask & CH_MASK;
         wmask_ff    <= req_bus.white_mask & CH_MASK;
         for (int i = 0; i < CHANNELS; i++) begin
            samp_ff[i] <= samp_in[i];
         end
      end
      if (update_fire) begin
         out_pos_ff    <= filt_in;
         out_det_ff    <= det_in;
         out_count_ff  <= last_count_in;
         out_mask_ff   <= last_mask_in;
         out_online_ff <= frame_ok_ff;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.filtered_position  = out_pos_ff;
   assign rsp_bus.line_detected      = out_det_ff;
   assign rsp_bus.dark_channel_count = out_count_ff;
   assign rsp_bus.track_mask         = out_mask_ff;
   assign rsp_bus.sensor_online      = out_online_ff;

   // checks
   `ASSERT_IMPLIES(a_ready_div_idle, clock, reset, req_bus.ready, !div_stat.busy)
   // with no darkness the quotient is meaningless and not bounded
   `ASSERT_IMPLIES(a_quot_bounded, clock, reset, ((state_ff == S_UPDATE) && (dark_sum != '0)),
      (div_stat.quotient <= MAX_MAG))
   `ASSERT_NEXT(a_fail_drops_line, clock, reset, (update_fire && !frame_ok_ff),
      (!det_ff && (acq_ff == 2'd0) && (lost_ff == 2'd0)))

endmodule

`default_nettype wire

// File: sv/lsct_lane.sv
// one channel lane: darkness and weighted darkness of a sample
`default_nettype none

module lsct_lane import lsct_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic                       chan_valid,
   input  wire logic [SAMPLE_W-1:0]        sample,
   input  wire logic [SAMPLE_W-1:0]        threshold,
   input  wire logic signed [WEIGHT_W-1:0] weight,
   output lane_result_type                 result
);

   lane_result_type result_ff;
   lane_result_type result_in;
   logic signed [PROD_W-1:0] prod;

   always_comb begin
      result_in.is_dark = chan_valid && (sample < threshold);
      result_in.dark    = result_in.is_dark ? (threshold - sample) : '0;
      prod              = $signed({1'b0, result_in.dark}) * weight;
      result_in.prod    = prod;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// File: sv/lsct_merge.sv
// merge stage: sums darkness, weighted darkness and dark count over lanes
`default_nettype none

module lsct_merge import lsct_pkg::*; (
   input  wire logic                clock,
   input  wire logic                load,
   input  lane_result_type          lanes [CHANNELS],
   output logic [DSUM_W-1:0]        dark_sum,
   output logic signed [WSUM_W-1:0] wdark_sum,
   output logic [COUNT_W-1:0]       dark_tally
);

   logic [DSUM_W-1:0]        dsum_ff, dsum_in;
   logic signed [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [COUNT_W-1:0]       dcount_ff, dcount_in;

   always_comb begin
      dsum_in   = '0;
      wsum_in   = '0;
      dcount_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         dsum_in   = dsum_in + DSUM_W'(lanes[i].dark);
         wsum_in   = wsum_in + WSUM_W'(lanes[i].prod);
         dcount_in = dcount_in + COUNT_W'(lanes[i].is_dark);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dsum_ff   <= dsum_in;
         wsum_ff   <= wsum_in;
         dcount_ff <= dcount_in;
      end
   end

   assign dark_sum   = dsum_ff;
   assign wdark_sum  = wsum_ff;
   assign dark_tally = dcount_ff;

endmodule

`default_nettype wire

// File: sv/lsct_divider.sv
// restoring divider, one quotient bit a cycle
`default_nettype none

module lsct_divider import lsct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numerator,
   input  wire logic [DSUM_W-1:0] denominator,
   output div_status_type         status
);

   localparam int REM_W = DSUM_W + 1;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUOT_W-1:0]    low_ff, low_in;
   logic [DSUM_W-1:0]    den_ff, den_in;
   logic [REM_W-1:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      trial   = {rem_ff[REM_W-2:0], low_ff[QUOT_W-1]};
      if (start) begin
         // quotient fits in QUOT_W bits, so the top part is below the divisor
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(QUOT_W);
         rem_in  = REM_W'(numerator[NUM_W-1:QUOT_W]);
         low_in  = numerator[QUOT_W-1:0];
         den_in  = denominator;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            low_in = {low_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            low_in = {low_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign status.busy     = busy_ff;
   assign status.quotient = low_ff;

endmodule

`default_nettype wire
